// ===== hw/rtl/mqdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi quadrature detent decoder package
// Shared constants, the lane control bundle and the transition lookup.
// ----------------------------------------------------------------------------
package mqdd_pkg;

    // Fixed field layout of the stream ports.
    localparam int MAX_ENCODERS  = 8;
    localparam int POS_FIELD_W   = 16;
    localparam int PINS_W        = 16;
    localparam int PIN_IDX_W     = 4;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = MAX_ENCODERS * POS_FIELD_W;
    localparam int OUT_USER_W    = 1;

    // Parameter defaults.
    localparam int NUM_ENCODERS_DEF  = 8;
    localparam int POSITION_BITS_DEF = 16;

    // Configuration register indexes and reset values.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIN_MAP_A    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIN_MAP_B    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEPS_DETENT = 2'd2;

    localparam logic [31:0] PIN_MAP_A_RESET = 32'hEC02_579A;
    localparam logic [31:0] PIN_MAP_B_RESET = 32'hFD13_648B;
    localparam logic [2:0]  DETENT_RESET    = 3'd4;

    // Per-sample control handed to every lane.
    typedef struct packed {
        logic       accept;    // a sample transfer happens this cycle
        logic       update;    // reference levels exist, so decode
        logic [2:0] detent;    // effective substeps per detent, 1 to 4
    } t_lane_ctl;

    // Gray-code transition value indexed by {prev_a, prev_b, cur_a, cur_b}.
    // No change and a double change both give zero.
    function automatic logic signed [1:0] gray_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        unique case (idx)
            4'h1, 4'h7, 4'h8, 4'hE: d = -2'sd1;
            4'h2, 4'h4, 4'hB, 4'hD: d = 2'sd1;
            default:                d = 2'sd0;
        endcase
        return d;
    endfunction

    // Zero acts as one, five to seven act as four.
    function automatic logic [2:0] eff_detent(input logic [2:0] k);
        logic [2:0] r;
        if (k == 3'd0) begin
            r = 3'd1;
        end else if (k > 3'd4) begin
            r = 3'd4;
        end else begin
            r = k;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mqdd_lane.sv =====
// ----------------------------------------------------------------------------
// Decoder lane
// Picks one encoder's A and B pins, tracks its substep and detent count.
// ----------------------------------------------------------------------------
module mqdd_lane
    import mqdd_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic [PINS_W-1:0]        i_pins,
    input  logic [PIN_IDX_W-1:0]     i_pin_a,
    input  logic [PIN_IDX_W-1:0]     i_pin_b,
    output logic [POSITION_BITS-1:0] o_next_position
);

    logic                     r_prev_a;
    logic                     r_prev_b;
    logic signed [2:0]        r_substep;
    logic [POSITION_BITS-1:0] r_position;

    logic                     w_cur_a;
    logic                     w_cur_b;
    logic signed [1:0]        w_delta;
    logic signed [3:0]        w_sum;
    logic signed [3:0]        w_k;
    logic signed [2:0]        n_substep;
    logic [POSITION_BITS-1:0] n_position;

    assign w_cur_a = i_pins[i_pin_a];
    assign w_cur_b = i_pins[i_pin_b];
    assign w_delta = gray_delta({r_prev_a, r_prev_b, w_cur_a, w_cur_b});
    assign w_sum   = {r_substep[2], r_substep} + {{2{w_delta[1]}}, w_delta};
    assign w_k     = {1'b0, i_ctl.detent};

    always_comb begin
        n_substep  = r_substep;
        n_position = r_position;
        if (i_ctl.update) begin
            if (w_sum >= w_k) begin
                n_substep  = 3'(w_sum - w_k);
                n_position = r_position + POSITION_BITS'(1);
            end else if (w_sum <= -w_k) begin
                n_substep  = 3'(w_sum + w_k);
                n_position = r_position - POSITION_BITS'(1);
            end else begin
                n_substep  = 3'(w_sum);
            end
        end
    end

    assign o_next_position = n_position;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a   <= 1'b0;
            r_prev_b   <= 1'b0;
            r_substep  <= 3'sd0;
            r_position <= '0;
        end else if (i_ctl.accept) begin
            r_prev_a   <= w_cur_a;
            r_prev_b   <= w_cur_b;
            r_substep  <= n_substep;
            r_position <= n_position;
        end
    end

endmodule

// ===== hw/rtl/mqdd_outq.sv =====
// ----------------------------------------------------------------------------
// Result merge and output queue
// Packs the lane positions into one result and holds up to two results.
// ----------------------------------------------------------------------------
module mqdd_outq
    import mqdd_pkg::*;
#(
    parameter int NUM_ENCODERS  = NUM_ENCODERS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [POSITION_BITS-1:0] i_position [NUM_ENCODERS],
    input  logic                     i_initial,
    output logic                     o_space,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OUT_DATA_W-1:0]    o_data,
    output logic [OUT_USER_W-1:0]    o_user
);

    logic [OUT_DATA_W-1:0] w_data;
    logic [OUT_DATA_W-1:0] r_data [2];
    logic [OUT_USER_W-1:0] r_user [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_count;
    logic                  w_pop;

    // Encoder slots beyond the built lanes always read zero.
    for (genvar e = 0; e < MAX_ENCODERS; e++) begin : g_slot
        if (e < NUM_ENCODERS) begin : g_used
            if (POSITION_BITS >= POS_FIELD_W) begin : g_trunc
                assign w_data[e*POS_FIELD_W +: POS_FIELD_W] =
                    i_position[e][POS_FIELD_W-1:0];
            end else begin : g_ext
                assign w_data[e*POS_FIELD_W +: POS_FIELD_W] =
                    {{(POS_FIELD_W-POSITION_BITS){1'b0}}, i_position[e]};
            end
        end else begin : g_unused
            assign w_data[e*POS_FIELD_W +: POS_FIELD_W] = '0;
        end
    end

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_data  = r_data[r_rd_ptr];
    assign o_user  = r_user[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= w_data;
            r_user[r_wr_ptr] <= OUT_USER_W'(i_initial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
    end

endmodule

// ===== hw/rtl/multi_quadrature_detent_decoder.sv =====
// ----------------------------------------------------------------------------
// Multi quadrature detent decoder
// Decodes up to eight quadrature encoders from two sampled 8-bit pin ports.
// ----------------------------------------------------------------------------
// The block accepts one pin sample per clock cycle while the output queue
// has room and delivers one result per sample. Every encoder has its own
// lane that selects its A and B pins through the pin maps, looks up the
// Gray-code transition against the previous sample, accumulates substeps and
// moves the detent count by one each time steps_per_detent substeps are
// reached; all lanes update in the cycle of the transfer. A two-entry output
// queue lets the block keep taking samples while one result waits on the
// master side, so s_tready only drops when two results are pending. The first
// sample after reset only records the reference levels and is reported with
// the initial flag set. Configuration is written through a plain write port
// and should be changed only while no result is pending.
// ----------------------------------------------------------------------------
module multi_quadrature_detent_decoder
    import mqdd_pkg::*;
#(
    parameter int NUM_ENCODERS  = NUM_ENCODERS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    // Sample stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] port_a_levels, [15:8] port_b_levels

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // position_0 in [15:0] up to position_7
    output logic [OUT_USER_W-1:0] m_tuser    // [0] initial_sample
);

    logic [31:0] r_pin_map_a;
    logic [31:0] r_pin_map_b;
    logic [2:0]  r_steps;
    logic        r_ref_taken;

    logic                     w_accept;
    t_lane_ctl                w_ctl;
    logic [POSITION_BITS-1:0] w_next_pos [NUM_ENCODERS];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_map_a <= PIN_MAP_A_RESET;
            r_pin_map_b <= PIN_MAP_B_RESET;
            r_steps     <= DETENT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PIN_MAP_A:    r_pin_map_a <= i_cfg_wdata;
                CFG_PIN_MAP_B:    r_pin_map_b <= i_cfg_wdata;
                CFG_STEPS_DETENT: r_steps     <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // A transfer happens whenever a sample is valid and the output queue has room for its result.
    assign w_accept = s_tvalid && s_tready;

    // The first sample after reset only sets the reference levels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_taken <= 1'b0;
        end else if (w_accept) begin
            r_ref_taken <= 1'b1;
        end
    end

    assign w_ctl.accept = w_accept;
    assign w_ctl.update = r_ref_taken;
    assign w_ctl.detent = eff_detent(r_steps);

    // One lane per encoder; each picks its pins through its nibble of the maps.
    for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_lane
        mqdd_lane #(
            .POSITION_BITS (POSITION_BITS)
        ) u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_pins          (s_tdata),
            .i_pin_a         (r_pin_map_a[i*PIN_IDX_W +: PIN_IDX_W]),
            .i_pin_b         (r_pin_map_b[i*PIN_IDX_W +: PIN_IDX_W]),
            .o_next_position (w_next_pos[i])
        );
    end

    // The result of a sample carries the positions after that sample.
    mqdd_outq #(
        .NUM_ENCODERS  (NUM_ENCODERS),
        .POSITION_BITS (POSITION_BITS)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_position (w_next_pos),
        .i_initial  (!r_ref_taken),
        .o_space    (s_tready),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_data     (m_tdata),
        .o_user     (m_tuser)
    );

    // Every accepted sample leaves a result pending in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> m_tvalid)
        else $error("accepted sample produced no pending result");

    // The reference flag is set by the first transfer and reported once.
    a_reference_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_ref_taken) |=> (r_ref_taken && m_tvalid))
        else $error("reference sample not recorded");

    // Back pressure only appears while results are waiting.
    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // Reset empties the queue and reopens the input.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_tvalid && s_tready))
        else $error("reset did not clear the output queue");

endmodule
